[hw/rtl/emg_aw_pkg.sv]
// Shared constants and helpers for the EMG activity window block.
// Depends on nothing; imported by emg_activity_window_with_calibration.
`default_nettype none

package emg_aw_pkg;

   localparam int NUM_CHANNELS         = 8;
   localparam int SAMPLE_W             = 8;
   localparam int TIME_W               = 32;
   localparam int SYNC_TIME_W          = 16;
   localparam int OUT_SUM_W            = 14;
   localparam int WINDOW_DEPTH_DEFAULT = 8;

   // Largest magnitude of one sample is 128, so one item sums to at most 1024.
   localparam int MAG_W       = SAMPLE_W;
   localparam int ENTRY_MAX   = NUM_CHANNELS * 128;
   localparam int ENTRY_MAG_W = $clog2(ENTRY_MAX + 1);

   localparam logic [OUT_SUM_W-1:0]   SUM_MAX         = '1;
   localparam logic [SYNC_TIME_W-1:0] SYNC_TIME_RESET = 16'd5000;

   function automatic logic [MAG_W-1:0] mag8(input logic [SAMPLE_W-1:0] raw);
      logic [MAG_W-1:0] neg;
      neg = MAG_W'(~raw) + MAG_W'(1);
      return raw[SAMPLE_W-1] ? neg : MAG_W'(raw);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/emg_activity_window_with_calibration.sv]
// Top level of the EMG activity window with calibration peak tracking.
// Depends on emg_aw_pkg for widths, constants and the magnitude helper.
`default_nettype none

// The block takes one item per clock cycle unless the receiver stalls it, and
// returns one result per item. An accepted item is held in the input register;
// once it moves on, its result is offered from the result register in the next
// cycle. The input register moves on only when the result register is empty or
// its result is taken in the same cycle: a waiting result still lets one more
// item enter, and the input stalls once both registers are full.
// Each item's eight channel magnitudes are added into an exact running sum,
// and the magnitude of the item leaving the window (a shift line of
// WINDOW_DEPTH per-item sums, all zero after reset) is taken out. The first
// item starts the calibration window; the peak windowed sum is tracked until
// now_ms minus that start reaches sync_time_ms, when synced is set and
// sync_done marks that one result. Reported sums saturate at 16383.
module emg_activity_window_with_calibration
   import emg_aw_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_0,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_1,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_2,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_3,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_4,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_5,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_6,
   input  wire logic signed [SAMPLE_W-1:0]    req_channel_7,
   input  wire logic        [TIME_W-1:0]      req_now_ms,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic        [OUT_SUM_W-1:0]   rsp_window_sum,
   output      logic        [OUT_SUM_W-1:0]   rsp_reference_peak,
   output      logic                          rsp_synced,
   output      logic                          rsp_sync_done,
   input  wire logic                          csr_write_enable,
   input  wire logic        [SYNC_TIME_W-1:0] csr_write_data
);

   localparam int SUM_LIMIT = WINDOW_DEPTH * ENTRY_MAX;
   localparam int SUM_W     = $clog2(SUM_LIMIT + 1);
   localparam int CMP_W     = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;

   logic [SYNC_TIME_W-1:0] sync_time_ff;

   logic                   s1_valid_ff;
   logic [SAMPLE_W-1:0]    s1_chan_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]      s1_now_ff;

   logic [ENTRY_MAG_W-1:0] window_ff [WINDOW_DEPTH];
   logic [SUM_W-1:0]       running_sum_ff;
   logic [SUM_W-1:0]       running_sum_in;
   logic [TIME_W-1:0]      start_time_ff;
   logic                   started_ff;
   logic [OUT_SUM_W-1:0]   peak_ff;
   logic [OUT_SUM_W-1:0]   peak_in;
   logic                   synced_ff;
   logic                   synced_in;
   logic                   pulse_in;

   logic [ENTRY_MAG_W-1:0] new_mag;
   logic [CMP_W-1:0]       sum_ext;
   logic [OUT_SUM_W-1:0]   shown;
   logic [TIME_W-1:0]      start_eff;
   logic [TIME_W-1:0]      elapsed;
   logic                   advance;

   logic                   out_valid_ff;
   logic [OUT_SUM_W-1:0]   out_sum_ff;
   logic [OUT_SUM_W-1:0]   out_peak_ff;
   logic                   out_synced_ff;
   logic                   out_pulse_ff;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      new_mag = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         new_mag = new_mag + ENTRY_MAG_W'(mag8(s1_chan_ff[c]));
      end
      running_sum_in = running_sum_ff - SUM_W'(window_ff[WINDOW_DEPTH-1])
                       + SUM_W'(new_mag);
      sum_ext = CMP_W'(running_sum_in);
      if (sum_ext > CMP_W'(SUM_MAX)) begin
         shown = SUM_MAX;
      end else begin
         shown = sum_ext[OUT_SUM_W-1:0];
      end
      start_eff = started_ff ? start_time_ff : s1_now_ff;
      elapsed   = s1_now_ff - start_eff;
      peak_in   = peak_ff;
      synced_in = synced_ff;
      pulse_in  = 1'b0;
      if (!synced_ff) begin
         if (elapsed < TIME_W'(sync_time_ff)) begin
            if (shown > peak_ff) begin
               peak_in = shown;
            end
         end else begin
            synced_in = 1'b1;
            pulse_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_time_ff <= SYNC_TIME_RESET;
      end else if (csr_write_enable) begin
         sync_time_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_chan_ff[0] <= req_channel_0;
         s1_chan_ff[1] <= req_channel_1;
         s1_chan_ff[2] <= req_channel_2;
         s1_chan_ff[3] <= req_channel_3;
         s1_chan_ff[4] <= req_channel_4;
         s1_chan_ff[5] <= req_channel_5;
         s1_chan_ff[6] <= req_channel_6;
         s1_chan_ff[7] <= req_channel_7;
         s1_now_ff     <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         running_sum_ff <= '0;
         start_time_ff  <= '0;
         started_ff     <= 1'b0;
         peak_ff        <= '0;
         synced_ff      <= 1'b0;
      end else if (advance) begin
         window_ff[0] <= new_mag;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
         running_sum_ff <= running_sum_in;
         start_time_ff  <= start_eff;
         started_ff     <= 1'b1;
         peak_ff        <= peak_in;
         synced_ff      <= synced_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sum_ff    <= shown;
         out_peak_ff   <= peak_in;
         out_synced_ff <= synced_in;
         out_pulse_ff  <= pulse_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_window_sum     = out_sum_ff;
   assign rsp_reference_peak = out_peak_ff;
   assign rsp_synced         = out_synced_ff;
   assign rsp_sync_done      = out_pulse_ff;

   a_sum_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(running_sum_ff) <= CMP_W'(SUM_LIMIT))
      else $error("Running sum exceeds the largest possible window sum.");

   a_done_implies_synced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_done |-> rsp_synced)
      else $error("Sync done reported without the synced flag.");

   a_peak_frozen: assert property (@(posedge clock) disable iff (reset)
      synced_ff |=> $stable(peak_ff))
      else $error("Reference peak changed after calibration ended.");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      advance && synced_ff |=> !rsp_sync_done)
      else $error("Sync done repeated after calibration ended.");

endmodule

`default_nettype wire

[tb/sv/emg_activity_window_with_calibration_tb.sv]
// Testbench for the EMG activity window with calibration peak tracking.
// Depends on emg_aw_pkg and emg_activity_window_with_calibration; self-checking
// against an in-bench model of the window sum, the calibration peak and sync.
`timescale 1ns / 1ps

module emg_activity_window_with_calibration_tb;
   import emg_aw_pkg::*;

   localparam int WIN_DEPTH = WINDOW_DEPTH_DEFAULT;

   typedef struct packed {
      logic [TIME_W-1:0]                      stamp;
      logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0]  ch;
   } emg_sample_type;

   typedef struct packed {
      logic [OUT_SUM_W-1:0] window_sum;
      logic [OUT_SUM_W-1:0] reference_peak;
      logic                 synced;
      logic                 sync_done;
   } activity_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] req_ch = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_SUM_W-1:0] rsp_window_sum;
   logic [OUT_SUM_W-1:0] rsp_reference_peak;
   logic rsp_synced;
   logic rsp_sync_done;
   logic csr_write_enable = 1'b0;
   logic [SYNC_TIME_W-1:0] csr_write_data = '0;

   // Model state.
   int unsigned win_mag [WIN_DEPTH];
   int unsigned win_head = 0;
   int unsigned win_total = 0;
   logic [TIME_W-1:0] cal_start = '0;
   logic cal_started = 1'b0;
   int unsigned cal_peak = 0;
   logic cal_synced = 1'b0;
   logic [SYNC_TIME_W-1:0] sync_time_cfg = SYNC_TIME_RESET;

   activity_type expected_activity [$];
   logic [TIME_W-1:0] last_stamp = '0;
   int unsigned samples_sent = 0;
   int unsigned results_checked = 0;
   int unsigned sync_pulses = 0;
   int unsigned mismatch_count = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned rsp_stall_left = 0;
   bit rsp_steady = 1'b0;
   bit req_steady = 1'b0;

   always #2 clock = ~clock;

   emg_activity_window_with_calibration #(
      .WINDOW_DEPTH(WIN_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_0      (req_ch[0]),
      .req_channel_1      (req_ch[1]),
      .req_channel_2      (req_ch[2]),
      .req_channel_3      (req_ch[3]),
      .req_channel_4      (req_ch[4]),
      .req_channel_5      (req_ch[5]),
      .req_channel_6      (req_ch[6]),
      .req_channel_7      (req_ch[7]),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_sum     (rsp_window_sum),
      .rsp_reference_peak (rsp_reference_peak),
      .rsp_synced         (rsp_synced),
      .rsp_sync_done      (rsp_sync_done),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   function automatic activity_type predict_activity(input emg_sample_type s);
      activity_type r;
      int unsigned item_mag;
      int v;
      logic [TIME_W-1:0] elapsed;
      int unsigned shown;
      item_mag = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         v = int'($signed(s.ch[c]));
         item_mag += (v < 0) ? -v : v;
      end
      win_total = win_total - win_mag[win_head] + item_mag;
      win_mag[win_head] = item_mag;
      win_head = (win_head + 1) % WIN_DEPTH;
      if (!cal_started) begin
         cal_started = 1'b1;
         cal_start = s.stamp;
      end
      shown = (win_total > int'(SUM_MAX)) ? int'(SUM_MAX) : win_total;
      r.sync_done = 1'b0;
      if (!cal_synced) begin
         elapsed = s.stamp - cal_start;
         if (elapsed < TIME_W'(sync_time_cfg)) begin
            if (shown > cal_peak) begin
               cal_peak = shown;
            end
         end else begin
            cal_synced = 1'b1;
            r.sync_done = 1'b1;
         end
      end
      r.window_sum = OUT_SUM_W'(shown);
      r.reference_peak = OUT_SUM_W'(cal_peak);
      r.synced = cal_synced;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_channel();
      case ($urandom_range(0, 9))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'h00;
         3: return SAMPLE_W'($urandom_range(0, 8) - 4);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic emg_sample_type random_sample(input logic [TIME_W-1:0] stamp);
      emg_sample_type s;
      s.stamp = stamp;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s.ch[c] = rand_channel();
      end
      return s;
   endfunction

   function automatic emg_sample_type flat_sample(input logic [SAMPLE_W-1:0] level,
                                                  input logic [TIME_W-1:0] stamp);
      emg_sample_type s;
      s.stamp = stamp;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s.ch[c] = level;
      end
      return s;
   endfunction

   // Valid stays high after acceptance when gap is zero; the next call reuses it.
   task automatic send_sample(input emg_sample_type s, input int unsigned gap);
      req_valid <= 1'b1;
      req_ch <= s.ch;
      req_now_ms <= s.stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_activity.push_back(predict_activity(s));
      last_stamp = s.stamp;
      samples_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_paced(input emg_sample_type s);
      send_sample(s, req_steady ? 0 : pick_gap());
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_activity.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_sync_time(input logic [SYNC_TIME_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sync_time_cfg = value;
      @(posedge clock);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 40) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      activity_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_activity.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected, expected nothing, actual sum %0d",
                     $time, rsp_window_sum);
         end else begin
            want = expected_activity.pop_front();
            compare_field("window_sum", want.window_sum, rsp_window_sum);
            compare_field("reference_peak", want.reference_peak, rsp_reference_peak);
            compare_field("synced", want.synced, rsp_synced);
            compare_field("sync_done", want.sync_done, rsp_sync_done);
            results_checked++;
            if (rsp_sync_done) sync_pulses++;
         end
      end
   end

   // The receiver stalls at random unless rsp_steady is set; a requested hold is counted down here.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 3) == 0) rsp_stall_left = pick_gap();
         end
      end
   end

   // A start at time zero is an ordinary start; the reset sync time is still running.
   task automatic test_reset_sync_time();
      send_sample(flat_sample(8'h00, 32'd0), pick_gap());
      send_sample(random_sample(32'd4999), pick_gap());
   endtask

   task automatic test_channel_extremes();
      emg_sample_type s;
      wait_results_drained();
      write_sync_time(16'hffff);
      for (int i = 0; i < WIN_DEPTH; i++) begin
         send_paced(flat_sample(8'h80, last_stamp + 1));
      end
      send_paced(flat_sample(8'h7f, last_stamp + 1));
      send_paced(flat_sample(8'hff, last_stamp + 1));
      send_paced(flat_sample(8'h01, last_stamp + 1));
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s = flat_sample(8'h00, last_stamp + 1);
         s.ch[c] = (c % 2 == 0) ? 8'h80 : 8'h7f;
         send_paced(s);
      end
      send_paced(flat_sample(8'h00, last_stamp + 1));
   endtask

   task automatic test_random_calibration();
      int unsigned floor_ms;
      for (int phase = 0; phase < 4; phase++) begin
         wait_results_drained();
         floor_ms = (last_stamp - cal_start) + 20000;
         if (floor_ms > 65535) floor_ms = 65535;
         write_sync_time(SYNC_TIME_W'($urandom_range(65535, floor_ms)));
         req_steady = (phase == 2);
         rsp_steady = (phase == 1);
         for (int i = 0; i < 100; i++) begin
            send_paced(random_sample(last_stamp + $urandom_range(0, 30)));
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 150;
      for (int i = 0; i < 40; i++) begin
         send_sample(random_sample(last_stamp + 1), 0);
      end
      wait_results_drained();
   endtask

   // The item one below the sync time still counts; the one at it ends calibration.
   task automatic test_sync_boundary();
      logic [TIME_W-1:0] elapsed;
      wait_results_drained();
      elapsed = last_stamp + 1 - cal_start;
      write_sync_time(SYNC_TIME_W'(elapsed + 1));
      send_paced(flat_sample(8'h80, last_stamp + 1));
      send_paced(flat_sample(8'h80, last_stamp + 1));
      send_paced(flat_sample(8'h80, last_stamp));
   endtask

   // After sync the peak is frozen, even when elapsed time wraps or falls below the sync time.
   task automatic test_after_sync();
      wait_results_drained();
      write_sync_time(16'h0000);
      send_paced(flat_sample(8'h80, cal_start));
      wait_results_drained();
      write_sync_time(16'hffff);
      send_paced(flat_sample(8'h80, cal_start - 1));
      send_paced(flat_sample(8'h7f, cal_start + 1));
   endtask

   task automatic test_random_mixed();
      logic [TIME_W-1:0] stamp;
      for (int phase = 0; phase < 7; phase++) begin
         wait_results_drained();
         write_sync_time(SYNC_TIME_W'($urandom));
         req_steady = ($urandom_range(0, 2) == 0);
         rsp_steady = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 4) == 0) stamp = $urandom;
            else stamp = last_stamp + $urandom_range(0, 1000);
            send_paced(random_sample(stamp));
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sync_time();
      test_channel_extremes();
      test_random_calibration();
      test_backpressure();
      test_sync_boundary();
      test_after_sync();
      test_random_mixed();
      wait_results_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d samples, checked %0d results, saw %0d sync pulse(s).",
               samples_sent, results_checked, sync_pulses);
      $display("Final reference peak %0d, mismatches %0d.", cal_peak, mismatch_count);
      if (mismatch_count == 0 && expected_activity.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d results outstanding.", expected_activity.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
